FILE: rtl/pfp_pkg.sv
// Shared types for the plane-frame point projection block.
// No dependencies; imported by the frame unit, the dot lanes and the top level.
package pfp_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_A = 4'd0,
    REG_B = 4'd1,
    REG_C = 4'd2,
    REG_D = 4'd3
  } pfp_reg_e;

  // Frame derived from the plane registers: unit axes in Q2.30, origin in
  // the coordinate format, plus busy/degenerate status.
  typedef struct packed {
    logic             busy;
    logic             deg;
    logic [2:0][31:0] ex;
    logic [2:0][31:0] ey;
    logic [2:0][31:0] ez;
    logic [2:0][63:0] pos;
  } pfp_frame_t;

  // Load enables of the projection pipeline stages behind stage 1
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } pfp_en_t;

endpackage

FILE: rtl/pfp_frame.sv
// Frame unit: derives origin and unit axes from the plane registers.
// Sequential datapath with one shared multiplier, a bit-serial divider and
// a bit-serial square root. Depends on pfp_pkg.
module pfp_frame import pfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] plane_a_i,
  input  logic signed [31:0] plane_b_i,
  input  logic signed [31:0] plane_c_i,
  input  logic signed [31:0] plane_d_i,
  output pfp_frame_t         frame_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEL, ST_ODIV, ST_OFIN, ST_UVLOAD, ST_DOWN, ST_UP, ST_SQ,
    ST_ALIGN, ST_SQRT, ST_DIVLOAD, ST_UDIV, ST_UFIN, ST_CROSS
  } state_e;

  typedef enum logic [1:0] {
    VEC_Z = 2'd0,
    VEC_X = 2'd1,
    VEC_Y = 2'd2
  } vsel_e;

  state_e             state_q;
  vsel_e              vsel_q;
  logic [6:0]         cnt_q;
  logic [1:0]         idx_q;
  logic               deg_q;
  logic [1:0]         kidx_q;
  logic               neg_q;
  logic signed [63:0] xr_q [3];
  logic signed [63:0] v_q [3];
  logic [63:0]        m_q [3];
  logic [63:0]        big_q;
  logic [63:0]        acc_q;
  logic [63:0]        r_q;
  logic [63:0]        bit_q;
  logic [63:0]        n_q;
  logic [63:0]        div_n_q;
  logic [63:0]        div_d_q;
  logic [63:0]        div_r_q;
  logic [63:0]        div_q_q;
  logic signed [65:0] prod_q;
  logic signed [31:0] e_q [3][3];
  logic signed [63:0] pos_q [3];

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    mag64 = x[63] ? (~x + 64'd1) : x;
  endfunction

  // Axis selection and origin division setup
  logic [31:0]        aa, ab, ac, dmag, den;
  logic signed [63:0] a64, b64, c64;
  logic signed [63:0] xr [3];
  logic [1:0]         kidx;
  logic signed [31:0] kval;
  logic               plane_zero;
  logic [63:0]        onum;
  logic               oneg;

  always_comb begin
    aa  = mag32(plane_a_i);
    ab  = mag32(plane_b_i);
    ac  = mag32(plane_c_i);
    a64 = {{32{plane_a_i[31]}}, plane_a_i};
    b64 = {{32{plane_b_i[31]}}, plane_b_i};
    c64 = {{32{plane_c_i[31]}}, plane_c_i};
    if (ab <= aa && ab <= ac) begin
      if (aa > ac) begin
        kidx = 2'd0; xr[0] = -c64; xr[1] = '0; xr[2] = a64;
      end else begin
        kidx = 2'd2; xr[0] = c64;  xr[1] = '0; xr[2] = -a64;
      end
    end else if (aa <= ab && aa <= ac) begin
      if (ab > ac) begin
        kidx = 2'd1; xr[0] = '0; xr[1] = -c64; xr[2] = b64;
      end else begin
        kidx = 2'd2; xr[0] = '0; xr[1] = c64;  xr[2] = -b64;
      end
    end else begin
      if (aa > ab) begin
        kidx = 2'd0; xr[0] = -b64; xr[1] = a64;  xr[2] = '0;
      end else begin
        kidx = 2'd1; xr[0] = b64;  xr[1] = -a64; xr[2] = '0;
      end
    end
    case (kidx)
      2'd0:    kval = plane_a_i;
      2'd1:    kval = plane_b_i;
      default: kval = plane_c_i;
    endcase
    plane_zero = (plane_a_i == 32'sd0) && (plane_b_i == 32'sd0) && (plane_c_i == 32'sd0);
    dmag = mag32(plane_d_i);
    den  = mag32(kval);
    // (|d| << 30) + den/2, rounded quotient taken by the divider
    onum = ({32'd0, dmag} << 30) + {33'd0, den[31:1]};
    oneg = (plane_d_i != 32'sd0) && (plane_d_i[31] == kval[31]);
  end

  // Restoring divider step, one quotient bit per cycle
  logic [64:0] div_rs, div_rsub;
  logic        div_ge;

  always_comb begin
    div_rs   = {div_r_q, div_n_q[63]};
    div_ge   = div_rs >= {1'b0, div_d_q};
    div_rsub = div_rs - {1'b0, div_d_q};
  end

  // Square root step
  logic [63:0] sq_rb;
  logic        sq_ge;

  assign sq_rb = r_q + bit_q;
  assign sq_ge = acc_q >= sq_rb;

  // Magnitudes and largest component of the vector being normalized
  logic [63:0] mv [3];
  logic [63:0] bigv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mv[i] = mag64(v_q[i]);
    end
    bigv = mv[0];
    if (mv[1] > bigv) bigv = mv[1];
    if (mv[2] > bigv) bigv = mv[2];
  end

  // Shared multiplier operands: squares of scaled magnitudes, cross terms
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [1:0]         sq_sel;
  logic [2:0]         cr_j;
  logic [1:0]         cr_vi;

  assign sq_sel = (cnt_q[1:0] == 2'd3) ? 2'd2 : cnt_q[1:0];
  assign cr_j   = cnt_q[2:0] - 3'd1;
  assign cr_vi  = cr_j[2:1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = $signed({1'b0, m_q[sq_sel][31:0]});
        mul_b = $signed({1'b0, m_q[sq_sel][31:0]});
      end
      ST_CROSS: begin
        case (cnt_q[2:0])
          3'd0: begin
            mul_a = 33'(e_q[VEC_X][1]); mul_b = 33'(e_q[VEC_Z][2]);
          end
          3'd1: begin
            mul_a = 33'(e_q[VEC_X][2]); mul_b = 33'(e_q[VEC_Z][1]);
          end
          3'd2: begin
            mul_a = 33'(e_q[VEC_X][2]); mul_b = 33'(e_q[VEC_Z][0]);
          end
          3'd3: begin
            mul_a = 33'(e_q[VEC_X][0]); mul_b = 33'(e_q[VEC_Z][2]);
          end
          3'd4: begin
            mul_a = 33'(e_q[VEC_X][0]); mul_b = 33'(e_q[VEC_Z][1]);
          end
          3'd5: begin
            mul_a = 33'(e_q[VEC_X][1]); mul_b = 33'(e_q[VEC_Z][0]);
          end
          default: begin
            mul_a = '0; mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Unit-vector quotient with the sign of the source component
  logic [31:0] uq;
  assign uq = v_q[idx_q][63] ? (~div_q_q[31:0] + 32'd1) : div_q_q[31:0];

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEL;
      vsel_q  <= VEC_Z;
      cnt_q   <= '0;
      idx_q   <= '0;
      deg_q   <= 1'b0;
      kidx_q  <= '0;
      neg_q   <= 1'b0;
      big_q   <= '0;
      acc_q   <= '0;
      r_q     <= '0;
      bit_q   <= '0;
      n_q     <= '0;
      div_n_q <= '0;
      div_d_q <= '0;
      div_r_q <= '0;
      div_q_q <= '0;
      prod_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        xr_q[i]  <= '0;
        v_q[i]   <= '0;
        m_q[i]   <= '0;
        pos_q[i] <= '0;
        for (int j = 0; j < 3; j++) begin
          e_q[i][j] <= '0;
        end
      end
    end else begin
      prod_q <= mul_p;
      case (state_q)
        ST_IDLE: ;
        ST_SEL: begin
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= '0;
          end
          if (plane_zero) begin
            deg_q   <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            deg_q   <= 1'b0;
            kidx_q  <= kidx;
            neg_q   <= oneg;
            for (int i = 0; i < 3; i++) begin
              xr_q[i] <= xr[i];
            end
            div_n_q <= onum;
            div_d_q <= {32'd0, den};
            div_r_q <= '0;
            div_q_q <= '0;
            cnt_q   <= '0;
            state_q <= ST_ODIV;
          end
        end
        ST_ODIV, ST_UDIV: begin
          div_r_q <= div_ge ? div_rsub[63:0] : div_rs[63:0];
          div_q_q <= {div_q_q[62:0], div_ge};
          div_n_q <= {div_n_q[62:0], 1'b0};
          cnt_q   <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) begin
            state_q <= (state_q == ST_ODIV) ? ST_OFIN : ST_UFIN;
          end
        end
        ST_OFIN: begin
          pos_q[kidx_q] <= neg_q ? (~div_q_q + 64'd1) : div_q_q;
          v_q[0]  <= a64;
          v_q[1]  <= b64;
          v_q[2]  <= c64;
          vsel_q  <= VEC_Z;
          state_q <= ST_UVLOAD;
        end
        ST_UVLOAD: begin
          for (int i = 0; i < 3; i++) begin
            m_q[i] <= mv[i];
          end
          big_q <= bigv;
          if (bigv == 64'd0) begin
            for (int i = 0; i < 3; i++) begin
              e_q[vsel_q][i] <= '0;
            end
            case (vsel_q)
              VEC_Z: begin
                for (int i = 0; i < 3; i++) begin
                  v_q[i] <= xr_q[i];
                end
                vsel_q  <= VEC_X;
                state_q <= ST_UVLOAD;
              end
              VEC_X: begin
                cnt_q   <= '0;
                state_q <= ST_CROSS;
              end
              default: state_q <= ST_IDLE;
            endcase
          end else begin
            state_q <= ST_DOWN;
          end
        end
        // scale down, truncating, until the largest is at most 2^31
        ST_DOWN: begin
          if (big_q > 64'h0000_0000_8000_0000) begin
            for (int i = 0; i < 3; i++) begin
              m_q[i] <= m_q[i] >> 1;
            end
            big_q <= big_q >> 1;
          end else begin
            state_q <= ST_UP;
          end
        end
        // scale up until the largest is at least 2^30
        ST_UP: begin
          if (big_q < 64'h0000_0000_4000_0000) begin
            for (int i = 0; i < 3; i++) begin
              m_q[i] <= m_q[i] << 1;
            end
            big_q <= big_q << 1;
          end else begin
            acc_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_SQ;
          end
        end
        // sum of squares, one product per cycle
        ST_SQ: begin
          if (cnt_q[1:0] != 2'd0) begin
            acc_q <= acc_q + prod_q[63:0];
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q[1:0] == 2'd3) begin
            bit_q   <= 64'h4000_0000_0000_0000;
            r_q     <= '0;
            state_q <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (bit_q > acc_q) begin
            bit_q <= bit_q >> 2;
          end else begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (bit_q != 64'd0) begin
            if (sq_ge) begin
              acc_q <= acc_q - sq_rb;
              r_q   <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end else begin
            n_q     <= r_q;
            idx_q   <= '0;
            state_q <= ST_DIVLOAD;
          end
        end
        // round(m * 2^30 / n), ties up
        ST_DIVLOAD: begin
          div_n_q <= (m_q[idx_q] << 30) + (n_q >> 1);
          div_d_q <= n_q;
          div_r_q <= '0;
          div_q_q <= '0;
          cnt_q   <= '0;
          state_q <= ST_UDIV;
        end
        ST_UFIN: begin
          e_q[vsel_q][idx_q] <= uq;
          if (idx_q == 2'd2) begin
            case (vsel_q)
              VEC_Z: begin
                for (int i = 0; i < 3; i++) begin
                  v_q[i] <= xr_q[i];
                end
                vsel_q  <= VEC_X;
                state_q <= ST_UVLOAD;
              end
              VEC_X: begin
                cnt_q   <= '0;
                state_q <= ST_CROSS;
              end
              default: state_q <= ST_IDLE;
            endcase
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= ST_DIVLOAD;
          end
        end
        // y raw = x cross z, exact products
        ST_CROSS: begin
          if (cnt_q[2:0] != 3'd0) begin
            if (!cr_j[0]) begin
              v_q[cr_vi] <= prod_q[63:0];
            end else begin
              v_q[cr_vi] <= v_q[cr_vi] - prod_q[63:0];
            end
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q[2:0] == 3'd6) begin
            vsel_q  <= VEC_Y;
            state_q <= ST_UVLOAD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (start_i) begin
        state_q <= ST_SEL;
      end
    end
  end

  // Frame outputs
  always_comb begin
    frame_o.busy = (state_q != ST_IDLE);
    frame_o.deg  = deg_q;
    for (int i = 0; i < 3; i++) begin
      frame_o.ex[i]  = e_q[VEC_X][i];
      frame_o.ey[i]  = e_q[VEC_Y][i];
      frame_o.ez[i]  = e_q[VEC_Z][i];
      frame_o.pos[i] = pos_q[i];
    end
  end

endmodule

FILE: rtl/pfp_dot.sv
// One coordinate lane: biased offset dotted with a Q2.30 unit axis,
// rounded and saturated. Stages 2 to 4 of the projection pipeline.
// Depends on pfp_pkg.
module pfp_dot import pfp_pkg::*; (
  input  logic               clk_i,
  input  pfp_en_t            en_i,
  input  logic [2:0][62:0]   bias_i,
  input  logic [2:0][31:0]   axis_i,
  input  logic               deg_i,
  output logic signed [31:0] coord_o
);

  logic signed [33:0] oh [3];
  logic signed [30:0] ol [3];
  logic signed [31:0] ax [3];
  logic signed [65:0] ph [3];
  logic signed [65:0] pl [3];
  logic signed [65:0] ph_q [3];
  logic signed [65:0] pl_q [3];
  logic signed [65:0] hi_q, lo_q;
  logic signed [65:0] lb, total;
  logic signed [31:0] sat;
  logic signed [31:0] coord_q;

  // Stage 2: split the biased offset into high and low parts, multiply
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      oh[k] = $signed({1'b0, bias_i[k][62:30]}) - 34'sd2147483648;
      ol[k] = $signed({1'b0, bias_i[k][29:0]});
      ax[k] = $signed(axis_i[k]);
      ph[k] = oh[k] * ax[k];
      pl[k] = ol[k] * ax[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      for (int k = 0; k < 3; k++) begin
        ph_q[k] <= ph[k];
        pl_q[k] <= pl[k];
      end
    end
  end

  // Stage 3: sums over the three components
  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      hi_q <= ph_q[0] + ph_q[1] + ph_q[2];
      lo_q <= pl_q[0] + pl_q[1] + pl_q[2];
    end
  end

  // Stage 4: round to nearest (ties up), saturate
  always_comb begin
    lb    = lo_q + 66'sh0_4000_0000_2000_0000;
    total = hi_q + (lb >>> 30) - 66'sd4294967296;
    if (total > 66'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (total < -66'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = total[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en4) begin
      coord_q <= deg_i ? 32'sd0 : sat;
    end
  end

  assign coord_o = coord_q;

endmodule

FILE: rtl/plane_frame_point_projection.sv
// Plane-frame point projection top level: configuration registers, frame
// unit, input stage and three coordinate lanes.
// Depends on pfp_pkg, pfp_frame and pfp_dot.
//
// Usage:
//   Configuration: write plane_a/b/c (Q2.30) and plane_d (Q16.16) through
//   cfg_valid_i/cfg_ready_o with cfg_index_i 0..3; other indexes are
//   ignored. cfg_ready_o is always high. Each write restarts the frame unit.
//   Frame derivation runs on one shared multiplier, a one-bit-per-cycle
//   divider and square root; in_stall_o is held high while it runs, also
//   for a degenerate plane. After reset the frame is derived from the
//   reset values the same way before the first point is taken.
//   Points: in_valid_i/in_stall_o carry point_x/y/z. Once the frame is ready
//   one point is taken per cycle while the pipeline is not stalled;
//   out_valid_o rises once the point has passed the input stage, products,
//   sums and rounding into the output register.
//   Stall: out_stall_i freezes the output register; earlier stages keep
//   filling empty slots, so points are still taken until the pipeline is
//   full. Nothing is lost or repeated.
//   Degenerate plane (a = b = c = 0): coordinates are zero, degenerate_o set.
module plane_frame_point_projection import pfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] coord_u_o,
  output logic signed [31:0] coord_v_o,
  output logic signed [31:0] coord_w_o,
  output logic               degenerate_o
);

  logic signed [31:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q;
  logic               cfg_wr;
  pfp_frame_t         frame;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_a_q <= 32'sd0;
      plane_b_q <= 32'sd0;
      plane_c_q <= 32'sh4000_0000;
      plane_d_q <= 32'sd0;
    end else if (cfg_wr) begin
      case (pfp_reg_e'(cfg_index_i))
        REG_A:   plane_a_q <= cfg_data_i;
        REG_B:   plane_b_q <= cfg_data_i;
        REG_C:   plane_c_q <= cfg_data_i;
        REG_D:   plane_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfp_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_wr),
    .plane_a_i (plane_a_q),
    .plane_b_i (plane_b_q),
    .plane_c_i (plane_c_q),
    .plane_d_i (plane_d_q),
    .frame_o   (frame)
  );

  // Pipeline flow control: a stage loads when empty or when the next loads
  logic    v1_q, v2_q, v3_q, v4_q, deg4_q;
  logic    rdy1, rdy2, rdy3, rdy4;
  logic    accept;
  pfp_en_t en;

  assign rdy4       = ~v4_q | ~out_stall_i;
  assign rdy3       = ~v3_q | rdy4;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_stall_o = frame.busy | ~rdy1;
  assign accept     = in_valid_i & ~in_stall_o;

  assign en.en2 = rdy2 & v1_q;
  assign en.en3 = rdy3 & v2_q;
  assign en.en4 = rdy4 & v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      deg4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (en.en4) deg4_q <= frame.deg;
    end
  end

  // Stage 1: offset from origin plus 2^61 bias, clamped to [0, 2^62]
  logic signed [31:0] pt [3];
  logic signed [65:0] w [3];
  logic [2:0][62:0]   bias_d;
  logic [2:0][62:0]   bias_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w[k] = {{34{pt[k][31]}}, pt[k]} - $signed({{2{frame.pos[k][63]}}, frame.pos[k]})
             + 66'sh0_2000_0000_0000_0000;
      if (w[k][65]) begin
        bias_d[k] = '0;
      end else if (w[k] > 66'sh0_4000_0000_0000_0000) begin
        bias_d[k] = 63'h4000_0000_0000_0000;
      end else begin
        bias_d[k] = w[k][62:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bias_q <= bias_d;
    end
  end

  // Coordinate lanes
  pfp_dot u_dot_u (
    .clk_i   (clk_i),
    .en_i    (en),
    .bias_i  (bias_q),
    .axis_i  (frame.ex),
    .deg_i   (frame.deg),
    .coord_o (coord_u_o)
  );

  pfp_dot u_dot_v (
    .clk_i   (clk_i),
    .en_i    (en),
    .bias_i  (bias_q),
    .axis_i  (frame.ey),
    .deg_i   (frame.deg),
    .coord_o (coord_v_o)
  );

  pfp_dot u_dot_w (
    .clk_i   (clk_i),
    .en_i    (en),
    .bias_i  (bias_q),
    .axis_i  (frame.ez),
    .deg_i   (frame.deg),
    .coord_o (coord_w_o)
  );

  assign out_valid_o  = v4_q;
  assign degenerate_o = deg4_q;

endmodule

FILE: rtl/pfp_checker.sv
// Port-level checker for the plane-frame point projection block, with the
// bind that attaches it to the top level. No package dependency.
module pfp_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        in_stall_o,
  input logic [31:0] coord_u_o,
  input logic [31:0] coord_v_o,
  input logic [31:0] coord_w_o,
  input logic        degenerate_o
);

  // A stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(coord_u_o) && $stable(coord_v_o)
      && $stable(coord_w_o) && $stable(degenerate_o))
    else $error("stalled result changed");

  // Degenerate plane gives zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> coord_u_o == 32'd0 && coord_v_o == 32'd0
      && coord_w_o == 32'd0)
    else $error("degenerate result with nonzero coordinates");

  // A register write restarts the frame unit, so points are held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("point request taken while frame is rebuilt");

endmodule

bind plane_frame_point_projection pfp_props u_pfp_props (.*);

FILE: verif/pfp_checker.sv
// Checker for the plane-frame point projection block: mirrors the plane
// registers, predicts the coordinates of every accepted point and compares them.
// Depends on pfp_pkg for the register indexes.
module pfp_checker import pfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] coord_u_i,
  input  logic signed [31:0] coord_v_i,
  input  logic signed [31:0] coord_w_i,
  input  logic               degenerate_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec_t [3];

  typedef struct {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] w;
    logic               deg;
  } coord_t;

  localparam longint OpClamp = 64'sd1 <<< 61;

  logic signed [31:0] pl_a, pl_b, pl_c, pl_d;
  coord_t             coord_q [$];

  // Integer square root, one result bit per pass
  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, bv;
    r  = 0;
    bv = 64'h1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= r + bv) begin
        x = x - (r + bv);
        r = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  // Q2.30 unit vector, magnitudes normalized into [2^30, 2^31] first
  function automatic void unit_q30(input vec_t v, output vec_t e);
    logic [63:0] m [3];
    logic [63:0] big, sum, n, q;
    big = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      e[0] = 0; e[1] = 0; e[2] = 0;
      return;
    end
    while (big > (64'h1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      big = big >> 1;
    end
    while (big < (64'h1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      big = big << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    n = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + n / 2) / n;
      e[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // Rounded (op . e) / 2^30 with the operand split into high and low parts
  function automatic logic signed [31:0] dot_q30(input vec_t op, input vec_t e);
    longint      hi, lo, oh, ol, total;
    logic [63:0] bb, lb;
    hi = 0;
    lo = 0;
    for (int i = 0; i < 3; i++) begin
      bb = 64'(op[i] + OpClamp);
      oh = longint'(bb >> 30) - (64'sd1 <<< 31);
      ol = longint'(bb & 64'h3FFF_FFFF);
      hi = hi + oh * e[i];
      lo = lo + ol * e[i];
    end
    lb = 64'(lo + (64'sd1 <<< 62) + (64'sd1 <<< 29));
    total = hi + (longint'(lb >> 30) - (64'sd1 <<< 32));
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return total[31:0];
  endfunction

  // Local frame from the current plane, then the point's coordinates in it
  function automatic coord_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                           logic signed [31:0] pz);
    coord_t      res;
    longint      a, b, c, d, k;
    logic [63:0] aa, ab, ac, num, den, q;
    vec_t        xr, yr, zr, ex, ey, ez, pos, op, pt;
    int          kidx;
    a = pl_a; b = pl_b; c = pl_c; d = pl_d;
    res = '{u: 0, v: 0, w: 0, deg: 1'b1};
    if (a == 0 && b == 0 && c == 0) return res;
    res.deg = 1'b0;
    aa = (a < 0) ? 64'(-a) : 64'(a);
    ab = (b < 0) ? 64'(-b) : 64'(b);
    ac = (c < 0) ? 64'(-c) : 64'(c);
    if (ab <= aa && ab <= ac) begin
      if (aa > ac) begin kidx = 0; xr = '{-c, 0, a}; end
      else begin kidx = 2; xr = '{c, 0, -a}; end
    end else if (aa <= ab && aa <= ac) begin
      if (ab > ac) begin kidx = 1; xr = '{0, -c, b}; end
      else begin kidx = 2; xr = '{0, c, -b}; end
    end else begin
      if (aa > ab) begin kidx = 0; xr = '{-b, a, 0}; end
      else begin kidx = 1; xr = '{b, -a, 0}; end
    end
    k = (kidx == 0) ? a : ((kidx == 1) ? b : c);
    // origin on the axis of the chosen component
    num = ((d < 0) ? 64'(-d) : 64'(d)) << 30;
    den = (k < 0) ? 64'(-k) : 64'(k);
    q = (num + den / 2) / den;
    pos = '{0, 0, 0};
    pos[kidx] = (d != 0 && ((d < 0) == (k < 0))) ? -longint'(q) : longint'(q);
    zr = '{a, b, c};
    unit_q30(zr, ez);
    unit_q30(xr, ex);
    yr[0] = ex[1] * ez[2] - ex[2] * ez[1];
    yr[1] = ex[2] * ez[0] - ex[0] * ez[2];
    yr[2] = ex[0] * ez[1] - ex[1] * ez[0];
    unit_q30(yr, ey);
    pt = '{longint'(px), longint'(py), longint'(pz)};
    for (int i = 0; i < 3; i++) begin
      op[i] = pt[i] - pos[i];
      if (op[i] > OpClamp) op[i] = OpClamp;
      if (op[i] < -OpClamp) op[i] = -OpClamp;
    end
    res.u = dot_q30(op, ex);
    res.v = dot_q30(op, ey);
    res.w = dot_q30(op, ez);
    return res;
  endfunction

  // Watch the three channels; all values are taken as they were before the edge
  always @(posedge clk_i or negedge rst_ni) begin
    coord_t exp_c;
    if (!rst_ni) begin
      pl_a <= '0;
      pl_b <= '0;
      pl_c <= 32'h4000_0000;
      pl_d <= '0;
      coord_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        coord_q.insert(coord_q.size(), project_point(point_x_i, point_y_i, point_z_i));
      if (out_valid_i && !out_stall_i) begin
        if (coord_q.size() == 0) begin
          $error("result with no request waiting: u=%0d v=%0d w=%0d",
                 coord_u_i, coord_v_i, coord_w_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_c = coord_q.pop_front();
          if (coord_u_i !== exp_c.u || coord_v_i !== exp_c.v ||
              coord_w_i !== exp_c.w || degenerate_i !== exp_c.deg)
            fail_count_o <= fail_count_o + 1;
          if (coord_u_i !== exp_c.u)
            $error("coord_u: expected %0d, got %0d", exp_c.u, coord_u_i);
          if (coord_v_i !== exp_c.v)
            $error("coord_v: expected %0d, got %0d", exp_c.v, coord_v_i);
          if (coord_w_i !== exp_c.w)
            $error("coord_w: expected %0d, got %0d", exp_c.w, coord_w_i);
          if (degenerate_i !== exp_c.deg)
            $error("degenerate: expected %0b, got %0b", exp_c.deg, degenerate_i);
        end
      end
      pending_o <= coord_q.size();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_A:   pl_a <= cfg_data_i;
          REG_B:   pl_b <= cfg_data_i;
          REG_C:   pl_c <= cfg_data_i;
          REG_D:   pl_d <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: verif/plane_frame_point_projection_test.sv
// Testbench top for the plane-frame point projection block: clock, reset,
// plane settings, point stimulus, output stalls and verdict.
// Depends on pfp_pkg, the block's RTL and pfp_checker.
module plane_frame_point_projection_test;
  import pfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam logic [31:0] SMin = 32'h8000_0000;
  localparam logic [31:0] SMax = 32'h7FFF_FFFF;

  logic               clk, rst_n;
  logic               cfg_valid, cfg_ready;
  logic [3:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid, in_stall;
  logic signed [31:0] pt_x, pt_y, pt_z;
  logic               out_valid, out_stall;
  logic signed [31:0] crd_u, crd_v, crd_w;
  logic               deg;
  int                 fail_count, pending, cycle_cnt;
  logic               no_gaps;

  plane_frame_point_projection dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(pt_x), .point_y_i(pt_y), .point_z_i(pt_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .coord_u_o(crd_u), .coord_v_o(crd_v), .coord_w_o(crd_w),
    .degenerate_o(deg)
  );

  pfp_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .point_x_i(pt_x), .point_y_i(pt_y), .point_z_i(pt_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .coord_u_i(crd_u), .coord_v_i(crd_v), .coord_w_i(crd_w),
    .degenerate_i(deg),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("plane_frame_point_projection regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls: bursts of random length, with open stretches
  int stall_left;
  logic stall_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      stall_mode <= 1'b0;
    end else if (stall_left == 0) begin
      stall_mode <= ($urandom_range(3) == 0);
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      out_stall  <= stall_mode ? ($urandom_range(2) != 0) : 1'b0;
    end
  end

  function automatic logic [31:0] edge_val();
    case ($urandom_range(5))
      0: return SMin;
      1: return SMax;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h1;
      default: return 32'h4000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom();
    if (r < 75) return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
    if (r < 90) return edge_val();
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] rand_normal();
    int r;
    r = $urandom_range(99);
    if (r < 45) return $urandom();
    if (r < 60) return edge_val();
    if (r < 75) return 32'h0;
    return 32'($signed($urandom_range(0, 2000)) - 1000);
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    write_reg(REG_A, a);
    write_reg(REG_B, b);
    if ($urandom_range(2) == 0) write_reg(4'($urandom_range(4, 15)), $urandom());
    write_reg(REG_C, c);
    write_reg(REG_D, d);
  endtask

  // One point request; valid stays high across back-to-back requests
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pt_x <= x;
    pt_y <= y;
    pt_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  // Let the checker see the last request before waiting on the count
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_points(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(3) == 0);
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    no_gaps = 1'b0;
  endtask

  logic [31:0] dir_pts [10][3];

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; pt_x = '0; pt_y = '0; pt_z = '0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points under the reset plane z = 0
    dir_pts = '{'{SMin, SMin, SMin}, '{SMax, SMax, SMax}, '{0, 0, 0},
                '{SMin, SMax, 0}, '{SMax, SMin, 32'hFFFF_FFFF}, '{1, 32'hFFFF_FFFF, 1},
                '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000}, '{0, 0, SMax},
                '{0, 0, SMin}, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F}};
    foreach (dir_pts[i]) send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);
    drain();

    // Degenerate plane
    set_plane(0, 0, 0, $urandom());
    for (int i = 0; i < 5; i++) send_point(edge_val(), rand_coord(), edge_val());
    drain();

    // Far origin: tiny a with extreme d pushes the operands into the clamp
    set_plane(1, 0, 0, SMin);
    for (int i = 0; i < 5; i++) send_point(edge_val(), rand_coord(), rand_coord());
    drain();
    set_plane(0, 32'hFFFF_FFFF, 0, SMax);
    random_points(40);
    drain();

    // Extreme normals
    set_plane(SMin, SMin, SMin, SMax);
    random_points(60);
    drain();
    set_plane(SMax, 0, SMax, SMin);
    random_points(60);
    drain();
    set_plane(0, SMax, SMin, 0);
    random_points(60);
    drain();

    // Random planes
    for (int ph = 0; ph < 10; ph++) begin
      set_plane(rand_normal(), rand_normal(), rand_normal(),
                ($urandom_range(3) == 0) ? edge_val() : rand_coord());
      random_points(85);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("plane_frame_point_projection regression: pass");
    end else begin
      $display("plane_frame_point_projection regression: fail");
    end
    $finish;
  end

endmodule
